[design/ralr_pkg.sv]
// Shared constants and types for the register access link responder.
// Used by ralr_regfile and register_access_link_responder; no dependencies.
`default_nettype none

package ralr_pkg;

    localparam int REG_COUNT      = 32;
    localparam int FIRST_WRITABLE = 8;
    localparam int ADDR_W         = $clog2(REG_COUNT);
    localparam int CNT_W          = $clog2(REG_COUNT + 1);

    localparam logic [7:0] REG_COUNT_B      = 8'(REG_COUNT);
    localparam logic [7:0] FIRST_WRITABLE_B = 8'(FIRST_WRITABLE);

    localparam logic [7:0] KIND_PING   = 8'h01;
    localparam logic [7:0] KIND_READ   = 8'h02;
    localparam logic [7:0] KIND_WRITE  = 8'h03;
    localparam logic [7:0] REPLY_PONG  = 8'h11;
    localparam logic [7:0] REPLY_REG   = 8'h12;
    localparam logic [7:0] FRAME_START = 8'hFF;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_wr_req;

endpackage

`default_nettype wire

[design/register_access_link_responder.sv]
// Slave side of a byte-framed register link: message parsing, writes and replies.
// Depends on ralr_pkg and ralr_regfile.
// An input word is taken when valid in S_IDLE; after the last byte, a reply starts from S_FF or S_ECHO.
// While the receiver is ready, a reply streams one word per cycle from the output register; register bytes are
// prefetched from the register file into its registered read data through its single read port.
// No input word is taken until the last reply word has been loaded into the output register.
// Synchronous active-low reset clears the state machine, message tracking, output valid and register file valid bits.
`default_nettype none

module register_access_link_responder
    import ralr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [23:0] i_s_tdata,  // msg_byte[7:0], local_addr[12:8], local_value[20:13]
    input  wire logic        i_s_tlast,
    input  wire logic        i_s_tuser,  // func
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [7:0]       o_m_tdata,  // out_byte[7:0]
    output logic             o_m_tlast
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FF   = 3'd1;
    localparam logic [2:0] S_LEN  = 3'd2;
    localparam logic [2:0] S_KIND = 3'd3;
    localparam logic [2:0] S_DATA = 3'd4;
    localparam logic [2:0] S_SUM  = 3'd5;
    localparam logic [2:0] S_ECHO = 3'd6;

    logic [2:0]        r_state, n_state;
    logic [7:0]        r_pos, n_pos;
    logic [7:0]        r_msg_kind, n_msg_kind;
    logic [7:0]        r_start, n_start;
    logic [7:0]        r_count, n_count;
    logic              r_refused, n_refused;
    logic [7:0]        r_len, n_len;
    logic [7:0]        r_rkind, n_rkind;
    logic [7:0]        r_sum, n_sum;
    logic [CNT_W-1:0]  r_remain, n_remain;
    logic [ADDR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic              r_out_valid, n_out_valid;
    logic [7:0]        r_out_byte, n_out_byte;
    logic              r_out_last, n_out_last;

    logic              w_acc;
    logic              w_load;
    logic [7:0]        w_byte;
    logic [7:0]        w_laddr;
    logic [8:0]        w_target;
    logic [8:0]        w_end;
    logic              w_rd_en;
    logic [7:0]        w_rd_data;
    t_wr_req           w_wr;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_acc      = i_s_tvalid && o_s_tready;
    assign w_load     = !r_out_valid || i_m_tready;
    assign w_byte     = i_s_tdata[7:0];
    assign w_laddr    = {3'b000, i_s_tdata[12:8]};
    assign w_target   = {1'b0, r_start} + {1'b0, r_pos} - 9'd2;
    assign w_end      = {1'b0, n_start} + {1'b0, n_count};

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_msg_kind  = r_msg_kind;
        n_start     = r_start;
        n_count     = r_count;
        n_refused   = r_refused;
        n_len       = r_len;
        n_rkind     = r_rkind;
        n_sum       = r_sum;
        n_remain    = r_remain;
        n_rd_ptr    = r_rd_ptr;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        w_rd_en     = 1'b0;
        w_wr.en     = 1'b0;
        w_wr.addr   = w_laddr[ADDR_W-1:0];
        w_wr.data   = i_s_tdata[20:13];

        unique case (r_state)
            S_IDLE: begin
                if (w_acc && i_s_tuser) begin
                    w_wr.en = (w_laddr < REG_COUNT_B);
                end else if (w_acc) begin
                    if (r_pos == 8'd0) begin
                        n_msg_kind = w_byte;
                    end else if (r_pos == 8'd1) begin
                        n_start   = w_byte;
                        n_refused = (w_byte < FIRST_WRITABLE_B);
                    end else begin
                        if (r_pos == 8'd2) begin
                            n_count = w_byte;
                        end
                        w_wr.addr = w_target[ADDR_W-1:0];
                        w_wr.data = w_byte;
                        w_wr.en   = (r_msg_kind == KIND_WRITE) && !r_refused
                                    && (w_target < {1'b0, REG_COUNT_B});
                    end
                    if (i_s_tlast) begin
                        n_pos = 8'd0;
                        if (n_msg_kind == KIND_PING) begin
                            n_len    = 8'd2;
                            n_rkind  = REPLY_PONG;
                            n_remain = '0;
                            n_state  = S_FF;
                        end else if (n_msg_kind == KIND_READ) begin
                            if (r_pos >= 8'd2 && w_end <= {1'b0, REG_COUNT_B}) begin
                                n_len    = n_count + 8'd2;
                                n_rkind  = REPLY_REG;
                                n_remain = n_count[CNT_W-1:0];
                                n_rd_ptr = n_start[ADDR_W-1:0];
                                n_state  = S_FF;
                            end
                        end else if (n_msg_kind != KIND_WRITE) begin
                            n_state = S_ECHO;
                        end
                    end else if (r_pos != 8'hFF) begin
                        n_pos = r_pos + 8'd1;
                    end
                end
            end
            S_FF: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = FRAME_START;
                    n_out_last  = 1'b0;
                    n_state     = S_LEN;
                end
            end
            S_LEN: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_len;
                    n_out_last  = 1'b0;
                    n_sum       = r_len;
                    n_state     = S_KIND;
                end
            end
            S_KIND: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_rkind;
                    n_out_last  = 1'b0;
                    n_sum       = r_sum + r_rkind;
                    if (r_remain != '0) begin
                        w_rd_en  = 1'b1;
                        n_rd_ptr = r_rd_ptr + ADDR_W'(1);
                        n_state  = S_DATA;
                    end else begin
                        n_state = S_SUM;
                    end
                end
            end
            S_DATA: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = w_rd_data;
                    n_out_last  = 1'b0;
                    n_sum       = r_sum + w_rd_data;
                    n_remain    = r_remain - CNT_W'(1);
                    if (r_remain != CNT_W'(1)) begin
                        w_rd_en  = 1'b1;
                        n_rd_ptr = r_rd_ptr + ADDR_W'(1);
                    end else begin
                        n_state = S_SUM;
                    end
                end
            end
            S_SUM: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = ~r_sum;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_ECHO: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_msg_kind;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    ralr_regfile u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_wr),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_rd_ptr),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= 8'd0;
            r_msg_kind  <= 8'd0;
            r_start     <= 8'd0;
            r_count     <= 8'd0;
            r_refused   <= 1'b0;
            r_remain    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_msg_kind  <= n_msg_kind;
            r_start     <= n_start;
            r_count     <= n_count;
            r_refused   <= n_refused;
            r_remain    <= n_remain;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len      <= n_len;
        r_rkind    <= n_rkind;
        r_sum      <= n_sum;
        r_rd_ptr   <= n_rd_ptr;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tlast  = r_out_last;

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd_en |-> !w_wr.en)
        else $error("Register file read and write in the same cycle.");

    a_write_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr.en |-> w_acc)
        else $error("Register file written without an accepted word.");

    a_data_remaining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DATA) |-> (r_remain != '0))
        else $error("Data phase entered with no register bytes left.");

    a_sum_closes_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM && w_load) |=> (o_m_tvalid && o_m_tlast))
        else $error("Checksum word not presented as the last word.");

endmodule

`default_nettype wire

[design/ralr_regfile.sv]
// Register file memory with one write port and one registered read port.
// Depends on ralr_pkg; per-entry valid bits make unwritten entries read as zero.
`default_nettype none

module ralr_regfile
    import ralr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_wr_req           i_wr,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic [7:0]             o_rd_data
);

    logic [7:0]     r_mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_valid;
    logic [7:0]     r_rd_data;
    logic           r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : 8'h00;

endmodule

`default_nettype wire

[tb/tb_register_access_link_responder.sv]
// Testbench for register_access_link_responder: drives host message bytes and local
// register updates, predicts every reply word and checks it on the output stream.
// Depends on ralr_pkg and the design sources only.
module tb_register_access_link_responder
    import ralr_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic              func;
        logic [7:0]        msg_byte;
        logic              last;
        logic [ADDR_W-1:0] laddr;
        logic [7:0]        lval;
    } t_in_word;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_reply_byte;

    typedef logic [7:0] t_byte_q[$];

    class reply_scoreboard;
        logic [7:0]  regs [REG_COUNT];
        logic [7:0]  body_pos;
        logic [7:0]  msg_kind;
        logic [7:0]  start_addr;
        logic [7:0]  read_count;
        logic        refused;
        t_reply_byte due[$];
        int          errors;

        function new();
            foreach (regs[i]) regs[i] = 8'h00;
            body_pos   = 8'h00;
            msg_kind   = 8'h00;
            start_addr = 8'h00;
            read_count = 8'h00;
            refused    = 1'b0;
            errors     = 0;
        endfunction

        function int pending();
            return due.size();
        endfunction

        function void queue_frame(logic [7:0] kind, int unsigned first, int unsigned n);
            logic [7:0] len;
            logic [7:0] sum;
            len = 8'(n + 2);
            sum = len + kind;
            due.push_back({FRAME_START, 1'b0});
            due.push_back({len, 1'b0});
            due.push_back({kind, 1'b0});
            for (int unsigned i = 0; i < n; i++) begin
                due.push_back({regs[first + i], 1'b0});
                sum = sum + regs[first + i];
            end
            due.push_back({~sum, 1'b1});
        endfunction

        function void take_word(t_in_word w);
            int unsigned pos;
            int unsigned target;
            pos = body_pos;
            if (w.func) begin
                if (w.laddr < REG_COUNT) regs[w.laddr] = w.lval;
                return;
            end
            if (pos == 0) begin
                msg_kind = w.msg_byte;
            end else if (pos == 1) begin
                start_addr = w.msg_byte;
                refused    = (w.msg_byte < FIRST_WRITABLE_B);
            end else begin
                if (pos == 2) read_count = w.msg_byte;
                if (msg_kind == KIND_WRITE && !refused) begin
                    target = start_addr + pos - 2;
                    if (target < REG_COUNT) regs[target] = w.msg_byte;
                end
            end
            if (w.last) begin
                if (msg_kind == KIND_PING) begin
                    queue_frame(REPLY_PONG, 0, 0);
                end else if (msg_kind == KIND_READ) begin
                    if (pos >= 2 && int'(start_addr) + int'(read_count) <= REG_COUNT)
                        queue_frame(REPLY_REG, start_addr, read_count);
                end else if (msg_kind != KIND_WRITE) begin
                    due.push_back({msg_kind, 1'b1});
                end
                body_pos = 8'h00;
            end else if (pos < 255) begin
                body_pos = 8'(pos + 1);
            end
        endfunction

        function void check_reply_byte(logic [7:0] data, logic last);
            t_reply_byte want;
            if (due.size() == 0) begin
                $display("%0t: unexpected reply word: expected none, got byte %h last %b",
                         $time, data, last);
                errors++;
                return;
            end
            want = due.pop_front();
            if (data !== want.data) begin
                $display("%0t: out_byte mismatch: expected %h, got %h", $time, want.data, data);
                errors++;
            end
            if (last !== want.last) begin
                $display("%0t: out_last mismatch: expected %b, got %b", $time, want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       s_tvalid  = 1'b0;
    t_in_word   s_word    = '0;
    logic       m_tready  = 1'b0;
    logic       o_s_tready;
    logic       o_m_tvalid;
    logic [7:0] o_m_tdata;
    logic       o_m_tlast;
    logic [23:0] s_tdata;

    int send_gap_pct  = 20;
    int recv_idle_pct = 57;
    int hold_seq      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int words_sent    = 0;

    reply_scoreboard board;

    assign s_tdata = {3'b000, s_word.lval, s_word.laddr, s_word.msg_byte};

    register_access_link_responder i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_word.last),
        .i_s_tuser  (s_word.func),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always #4 clk = ~clk;

    // A new hold request keeps the output stalled for a long stretch.
    always @(posedge clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= 400;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (o_m_tvalid && m_tready) board.check_reply_byte(o_m_tdata, o_m_tlast);
            if (s_tvalid && o_s_tready) board.take_word(s_word);
        end
    end

    function automatic t_in_word host_word(logic [7:0] b, logic last);
        t_in_word w;
        w.func     = 1'b0;
        w.msg_byte = b;
        w.last     = last;
        w.laddr    = ADDR_W'($urandom);
        w.lval     = 8'($urandom);
        return w;
    endfunction

    function automatic t_in_word local_word(int unsigned addr, logic [7:0] value);
        t_in_word w;
        w.func     = 1'b1;
        w.msg_byte = 8'($urandom);
        w.last     = 1'($urandom);
        w.laddr    = ADDR_W'(addr);
        w.lval     = value;
        return w;
    endfunction

    task automatic send_word(input t_in_word w);
        if ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_gap_pct) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_word   <= w;
        @(posedge clk);
        while (!o_s_tready) @(posedge clk);
        words_sent++;
    endtask

    task automatic send_body(input t_byte_q body);
        foreach (body[i]) begin
            if ($urandom_range(99) < 5)
                send_word(local_word($urandom_range(REG_COUNT - 1), 8'($urandom)));
            send_word(host_word(body[i], i == body.size() - 1));
        end
    endtask

    task automatic send_random_message();
        t_byte_q     body;
        int unsigned pick;
        int unsigned sel;
        int unsigned addr;
        int unsigned room;
        logic [7:0]  kind;
        pick = $urandom_range(99);
        sel  = $urandom_range(99);
        if (pick < 15) begin
            send_word(local_word($urandom_range(REG_COUNT - 1), 8'($urandom)));
            return;
        end
        if (pick < 30) begin
            body = {KIND_PING};
            repeat ($urandom_range(0, 2)) body.push_back(8'($urandom));
        end else if (pick < 60) begin
            addr = $urandom_range(REG_COUNT - 1);
            room = REG_COUNT - addr;
            body = {KIND_READ, 8'(addr)};
            if (sel < 5) begin
                body = {KIND_READ, 8'h00, REG_COUNT_B};
            end else if (sel < 15) begin
                if ($urandom_range(1)) body = {KIND_READ};
            end else if (sel < 27) begin
                addr = $urandom_range(255);
                body = {KIND_READ, 8'(addr)};
                if (addr >= REG_COUNT) body.push_back(8'($urandom));
                else body.push_back(8'($urandom_range(REG_COUNT - addr + 1, 255)));
            end else begin
                body.push_back(8'($urandom_range(0, (room < 8) ? room : 8)));
            end
            if (sel >= 15 && $urandom_range(9) == 0) body.push_back(8'($urandom));
        end else if (pick < 88) begin
            if (sel < 85) addr = $urandom_range(FIRST_WRITABLE, REG_COUNT - 1);
            else addr = $urandom_range(255);
            body = {KIND_WRITE, 8'(addr)};
            repeat ($urandom_range(0, 6)) body.push_back(8'($urandom));
            if (sel % 20 == 0) body = {KIND_WRITE};
        end else begin
            do kind = 8'($urandom);
            while (kind == KIND_PING || kind == KIND_READ || kind == KIND_WRITE);
            body = {kind};
            repeat ($urandom_range(0, 3)) body.push_back(8'($urandom));
        end
        send_body(body);
    endtask

    initial begin
        t_byte_q body;
        int      random_base;
        int      phase;
        board = new();
        phase = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        body = {KIND_PING};
        send_body(body);
        send_word(local_word(0, 8'hFF));
        send_word(local_word(REG_COUNT - 1, 8'hA5));
        body = {KIND_READ, 8'h00, REG_COUNT_B};
        send_body(body);
        body = {KIND_WRITE, FIRST_WRITABLE_B - 8'd1, 8'h11};
        send_body(body);
        body = {KIND_WRITE, REG_COUNT_B - 8'd1, 8'h5A, 8'hA5};
        send_body(body);
        body = {KIND_WRITE};
        send_body(body);
        body = {KIND_READ, 8'h1E};
        send_body(body);
        body = {KIND_READ, REG_COUNT_B - 8'd1, 8'h02};
        send_body(body);
        body = {8'hFF};
        send_body(body);
        body = {KIND_READ, 8'h1E, 8'h02, 8'h33, 8'h44};
        send_body(body);
        body = {KIND_PING, 8'h77};
        send_body(body);

        // A write body longer than the position counter can count.
        body = {KIND_WRITE, FIRST_WRITABLE_B};
        repeat (280) body.push_back(8'($urandom));
        send_body(body);
        body = {KIND_READ, 8'h00, REG_COUNT_B};
        send_body(body);

        random_base = words_sent;
        while (words_sent < random_base + 100) begin
            if (phase == 0 && words_sent >= random_base + 35) begin
                phase = 1;
                send_gap_pct = 57;
                recv_idle_pct <= 20;
            end
            if (phase == 1 && words_sent >= random_base + 70) begin
                phase = 2;
                send_gap_pct = 0;
                recv_idle_pct <= 0;
                hold_seq <= hold_seq + 1;
                body = {KIND_READ, 8'h00, REG_COUNT_B};
                send_body(body);
                repeat (12) begin
                    body = {KIND_PING};
                    send_body(body);
                end
            end
            send_random_message();
        end
        s_tvalid <= 1'b0;

        while (board.pending() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
